@@ hdl/polyline_char_rasterizer_core_defines.svh @@
// ----------------------------------------------------------------------------
// Polyline rasterizer assertion macros
// Concurrent assertion helpers clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_CHAR_RASTERIZER_CORE_DEFINES_SVH
`define POLYLINE_CHAR_RASTERIZER_CORE_DEFINES_SVH

// property holds at every edge
`define PCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define PCR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define PCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/pcr_pkg.sv @@
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared constants and types of the polyline character rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pcr_pkg;

  localparam logic [6:0] GridColumns  = 7'd64;
  localparam logic [6:0] GridRows     = 7'd64;
  localparam int unsigned CfgAddrW    = 3;
  localparam logic        RegColumns  = 1'b0;
  localparam logic        RegRows     = 1'b1;
  localparam int unsigned QueueDepth  = 2;

  typedef enum logic [2:0] {
    GL_DOT       = 3'd0,
    GL_DASH      = 3'd1,
    GL_BAR       = 3'd2,
    GL_SLASH     = 3'd3,
    GL_BACKSLASH = 3'd4
  } glyph_e;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_SEG  = 1'b1
  } back_state_e;

  // one accepted vertex: its dot and the segment that leads to it
  typedef struct packed {
    logic [5:0]        dot_x;
    logic [5:0]        dot_y;
    logic              x_major;
    logic [5:0]        seg_cnt;
    logic [5:0]        lo_major;
    logic [5:0]        base_minor;
    logic signed [6:0] q_init;
    logic signed [6:0] step;
    logic [5:0]        div;
    glyph_e            glyph;
  } seg_desc_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } q_rd_t;

endpackage

`default_nettype wire

@@ hdl/pcr_vertex_if.sv @@
// ----------------------------------------------------------------------------
// pcr_vertex_if
// Vertex channel: valid/ready handshake with a signed column and row.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcr_vertex_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] point_x;
  logic signed [7:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

`default_nettype wire

@@ hdl/pcr_pixel_if.sv @@
// ----------------------------------------------------------------------------
// pcr_pixel_if
// Pixel channel: valid/ready handshake with grid cell, glyph and last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcr_pixel_if;
  logic       valid;
  logic       ready;
  logic [5:0] pixel_x;
  logic [5:0] pixel_y;
  logic [2:0] glyph;
  logic       last;

  modport source (output valid, output pixel_x, output pixel_y, output glyph,
                  output last, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input glyph,
                  input last, output ready);
endinterface

`default_nettype wire

@@ hdl/polyline_char_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// polyline_char_rasterizer_core
// Polyline vertices in, character-grid pixels out: a dot per vertex and the
// interior pixels of each segment, with dash, bar, slash or backslash glyphs.
//
//   channel  dir  handshake             payload
//   vtx_i    in   valid/ready           point_x, point_y
//   pix_o    out  valid/ready           pixel_x, pixel_y, glyph, last
//   APB      in   psel/penable/pwrite   paddr, pwdata, prdata (columns, rows)
//
// A vertex yields its dot and then the interior pixels of its segment:
// max(|dx|, |dy|) pixels with a segment, the dot alone without, at most 63;
// the back-end stepper emits them in order along the major axis.
// A rejected (off-grid) vertex is still taken while the queue is not full, and yields no transfer.
// Reset clears the previous vertex and loads 64 into both grid registers.
// Up to two descriptors wait between front and back, so vertices are taken
// while a segment is still drawn; a stalled pix_o holds its pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_char_rasterizer_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  pcr_vertex_if.sink                     vtx_i,
  pcr_pixel_if.source                    pix_o,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [pcr_pkg::CfgAddrW-1:0]    paddr,
  input  wire [31:0]                     pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [6:0] cols_q, cols_d;
  logic [6:0] rows_q, rows_d;
  logic       cfg_wr;

  pcr_pkg::seg_desc_t wr_desc, rd_desc;
  pcr_pkg::q_wr_t     wr_stat;
  pcr_pkg::q_rd_t     rd_stat;
  logic               push, pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cols_d = cols_q;
    rows_d = rows_q;
    if (cfg_wr) begin
      case (paddr[2])
        pcr_pkg::RegColumns: cols_d = pwdata[6:0];
        pcr_pkg::RegRows:    rows_d = pwdata[6:0];
        default:             cols_d = cols_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pcr_pkg::RegColumns: prdata = {25'd0, cols_q};
      pcr_pkg::RegRows:    prdata = {25'd0, rows_q};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= pcr_pkg::GridColumns;
      rows_q <= pcr_pkg::GridRows;
    end else begin
      cols_q <= cols_d;
      rows_q <= rows_d;
    end
  end

  pcr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vtx_i     (vtx_i),
    .columns_i (cols_q),
    .rows_i    (rows_q),
    .q_stat_i  (wr_stat),
    .push_o    (push),
    .desc_o    (wr_desc)
  );

  pcr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_desc_i (wr_desc),
    .pop_i     (pop),
    .rd_desc_o (rd_desc),
    .wr_stat_o (wr_stat),
    .rd_stat_o (rd_stat)
  );

  pcr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .desc_i   (rd_desc),
    .q_stat_i (rd_stat),
    .pop_o    (pop),
    .pix_o    (pix_o)
  );

endmodule

`default_nettype wire

@@ hdl/pcr_queue.sv @@
// ----------------------------------------------------------------------------
// pcr_queue
// Two-entry register queue of segment descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polyline_char_rasterizer_core_defines.svh"

module pcr_queue (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  pcr_pkg::seg_desc_t    wr_desc_i,
  input  wire                   pop_i,
  output pcr_pkg::seg_desc_t    rd_desc_o,
  output pcr_pkg::q_wr_t        wr_stat_o,
  output pcr_pkg::q_rd_t        rd_stat_o
);

  pcr_pkg::seg_desc_t entry_q [pcr_pkg::QueueDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= wr_desc_i;
    end
  end

  assign rd_desc_o       = entry_q[rd_ptr_q];
  assign wr_stat_o.push  = push_i;
  assign wr_stat_o.full  = (cnt_q == 2'd2);
  assign rd_stat_o.pop   = pop_i;
  assign rd_stat_o.empty = (cnt_q == 2'd0);

  `PCR_ASSERT(a_cnt_range, cnt_q <= 2'd2, "queue count out of range")
  `PCR_ASSERT_IMPL(a_no_underflow, pop_i, cnt_q != 2'd0, "pop from empty queue")
  `PCR_ASSERT_IMPL(a_no_overflow, push_i && !pop_i, cnt_q != 2'd2, "push into full queue")

endmodule

`default_nettype wire

@@ hdl/pcr_front.sv @@
// ----------------------------------------------------------------------------
// pcr_front
// Accept vertices, reject those off the grid, classify the segment from the
// previous vertex and hand a descriptor to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pcr_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  pcr_vertex_if.sink          vtx_i,
  input  wire [6:0]           columns_i,
  input  wire [6:0]           rows_i,
  input  pcr_pkg::q_wr_t      q_stat_i,
  output logic                push_o,
  output pcr_pkg::seg_desc_t  desc_o
);

  logic [5:0] px_q, px_d;
  logic [5:0] py_q, py_d;
  logic       have_prev_q, have_prev_d;

  logic [6:0]        xlim, ylim;
  logic              on_grid, xfer;
  logic [5:0]        nx, ny;
  logic signed [6:0] dx, dy, ndx, ndy;
  logic [5:0]        adx, ady;
  logic [8:0]        adx8, ady8;
  logic              have_seg, x_major;
  pcr_pkg::glyph_e   slope_gl;

  assign xlim = (columns_i > pcr_pkg::GridColumns) ? pcr_pkg::GridColumns : columns_i;
  assign ylim = (rows_i > pcr_pkg::GridRows) ? pcr_pkg::GridRows : rows_i;

  assign on_grid = !vtx_i.point_x[7] && (vtx_i.point_x[6:0] < xlim) &&
                   !vtx_i.point_y[7] && (vtx_i.point_y[6:0] < ylim);

  assign vtx_i.ready = !q_stat_i.full;
  assign xfer        = vtx_i.valid && !q_stat_i.full;
  assign push_o      = xfer && on_grid;

  assign nx  = vtx_i.point_x[5:0];
  assign ny  = vtx_i.point_y[5:0];
  assign dx  = $signed({1'b0, nx}) - $signed({1'b0, px_q});
  assign dy  = $signed({1'b0, ny}) - $signed({1'b0, py_q});
  assign ndx = -dx;
  assign ndy = -dy;
  assign adx = dx[6] ? ndx[5:0] : dx[5:0];
  assign ady = dy[6] ? ndy[5:0] : dy[5:0];
  assign adx8 = {adx, 3'b000};
  assign ady8 = {ady, 3'b000};

  assign have_seg = have_prev_q && ((adx != 6'd0) || (ady != 6'd0));
  assign x_major  = (adx >= ady);
  assign slope_gl = (dx[6] == dy[6]) ? pcr_pkg::GL_BACKSLASH : pcr_pkg::GL_SLASH;

  always_comb begin
    desc_o.dot_x   = nx;
    desc_o.dot_y   = ny;
    desc_o.x_major = x_major;
    if (x_major) begin
      desc_o.seg_cnt    = have_seg ? (adx - 6'd1) : 6'd0;
      desc_o.lo_major   = dx[6] ? nx : px_q;
      desc_o.base_minor = py_q;
      desc_o.q_init     = dx[6] ? dy : 7'sd0;
      desc_o.step       = dx[6] ? ndy : dy;
      desc_o.div        = adx;
      desc_o.glyph      = (ady8 < {3'b000, adx}) ? pcr_pkg::GL_DASH : slope_gl;
    end else begin
      desc_o.seg_cnt    = have_seg ? (ady - 6'd1) : 6'd0;
      desc_o.lo_major   = dy[6] ? ny : py_q;
      desc_o.base_minor = px_q;
      desc_o.q_init     = dy[6] ? dx : 7'sd0;
      desc_o.step       = dy[6] ? ndx : dx;
      desc_o.div        = ady;
      desc_o.glyph      = ({3'b000, ady} > adx8) ? pcr_pkg::GL_BAR : slope_gl;
    end
  end

  always_comb begin
    px_d        = px_q;
    py_d        = py_q;
    have_prev_d = have_prev_q;
    if (push_o) begin
      px_d        = nx;
      py_d        = ny;
      have_prev_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q        <= 6'd0;
      py_q        <= 6'd0;
      have_prev_q <= 1'b0;
    end else begin
      px_q        <= px_d;
      py_q        <= py_d;
      have_prev_q <= have_prev_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/pcr_back.sv @@
// ----------------------------------------------------------------------------
// pcr_back
// Emit the dot of each descriptor, then step the interior pixels along the
// major axis, tracking the exact floor of the minor offset by remainder.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polyline_char_rasterizer_core_defines.svh"

module pcr_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  pcr_pkg::seg_desc_t  desc_i,
  input  pcr_pkg::q_rd_t      q_stat_i,
  output logic                pop_o,
  pcr_pixel_if.source         pix_o
);

  pcr_pkg::back_state_e state_q, state_d;

  logic              xmaj_q, xmaj_d;
  logic [5:0]        major_q, major_d;
  logic [5:0]        base_q, base_d;
  logic signed [6:0] quo_q, quo_d;
  logic [5:0]        rem_acc_q, rem_acc_d;
  logic signed [6:0] step_q, step_d;
  logic [5:0]        div_q, div_d;
  logic [5:0]        left_q, left_d;
  pcr_pkg::glyph_e   glyph_q, glyph_d;

  logic            out_valid_q, out_valid_d;
  logic [5:0]      out_x_q, out_x_d;
  logic [5:0]      out_y_q, out_y_d;
  pcr_pkg::glyph_e out_gl_q, out_gl_d;
  logic            out_last_q, out_last_d;

  logic              load, emit;
  logic signed [7:0] rsum, rnext;
  logic signed [6:0] qnext;
  logic [5:0]        maj_next, minor;
  logic [7:0]        minor_sum;

  assign load = !out_valid_q || pix_o.ready;

  always_comb begin
    rsum  = $signed({2'b00, rem_acc_q}) + $signed({step_q[6], step_q});
    rnext = rsum;
    qnext = quo_q;
    if (rsum >= $signed({2'b00, div_q})) begin
      rnext = rsum - $signed({2'b00, div_q});
      qnext = quo_q + 7'sd1;
    end else if (rsum < 8'sd0) begin
      rnext = rsum + $signed({2'b00, div_q});
      qnext = quo_q - 7'sd1;
    end
    maj_next  = major_q + 6'd1;
    minor_sum = {2'b00, base_q} + {qnext[6], qnext};
    minor     = minor_sum[5:0];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pcr_pkg::BK_IDLE: begin
        if (load && !q_stat_i.empty && (desc_i.seg_cnt != 6'd0)) begin
          state_d = pcr_pkg::BK_SEG;
        end
      end
      pcr_pkg::BK_SEG: begin
        if (load && (left_q == 6'd1)) begin
          state_d = pcr_pkg::BK_IDLE;
        end
      end
      default: state_d = pcr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    pop_o      = 1'b0;
    out_x_d    = out_x_q;
    out_y_d    = out_y_q;
    out_gl_d   = out_gl_q;
    out_last_d = out_last_q;
    xmaj_d     = xmaj_q;
    major_d    = major_q;
    base_d     = base_q;
    quo_d      = quo_q;
    rem_acc_d  = rem_acc_q;
    step_d     = step_q;
    div_d      = div_q;
    left_d     = left_q;
    glyph_d    = glyph_q;
    case (state_q)
      pcr_pkg::BK_IDLE: begin
        if (load && !q_stat_i.empty) begin
          emit       = 1'b1;
          pop_o      = 1'b1;
          out_x_d    = desc_i.dot_x;
          out_y_d    = desc_i.dot_y;
          out_gl_d   = pcr_pkg::GL_DOT;
          out_last_d = (desc_i.seg_cnt == 6'd0);
          xmaj_d     = desc_i.x_major;
          major_d    = desc_i.lo_major;
          base_d     = desc_i.base_minor;
          quo_d      = desc_i.q_init;
          rem_acc_d  = 6'd0;
          step_d     = desc_i.step;
          div_d      = desc_i.div;
          left_d     = desc_i.seg_cnt;
          glyph_d    = desc_i.glyph;
        end
      end
      pcr_pkg::BK_SEG: begin
        if (load) begin
          emit       = 1'b1;
          out_x_d    = xmaj_q ? maj_next : minor;
          out_y_d    = xmaj_q ? minor : maj_next;
          out_gl_d   = glyph_q;
          out_last_d = (left_q == 6'd1);
          major_d    = maj_next;
          quo_d      = qnext;
          rem_acc_d  = rnext[5:0];
          left_d     = left_q - 6'd1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    out_valid_d = load ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pcr_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_gl_q   <= out_gl_d;
    out_last_q <= out_last_d;
    xmaj_q     <= xmaj_d;
    major_q    <= major_d;
    base_q     <= base_d;
    quo_q      <= quo_d;
    rem_acc_q  <= rem_acc_d;
    step_q     <= step_d;
    div_q      <= div_d;
    left_q     <= left_d;
    glyph_q    <= glyph_d;
  end

  assign pix_o.valid   = out_valid_q;
  assign pix_o.pixel_x = out_x_q;
  assign pix_o.pixel_y = out_y_q;
  assign pix_o.glyph   = out_gl_q;
  assign pix_o.last    = out_last_q;

  `PCR_ASSERT_IMPL(a_seg_left, state_q == pcr_pkg::BK_SEG, left_q != 6'd0,
                   "segment state with no pixels left")
  `PCR_ASSERT_IMPL(a_seg_rem, state_q == pcr_pkg::BK_SEG, rem_acc_q < div_q,
                   "step remainder not below divisor")
  `PCR_ASSERT_NEXT(a_last_idle, emit && out_last_d, state_q == pcr_pkg::BK_IDLE,
                   "last pixel sent but segment still running")

endmodule

`default_nettype wire

@@ test/pcr_raster_checker.sv @@
// ----------------------------------------------------------------------------
// pcr_raster_checker
// Watches the vertex, pixel and register ports of the polyline rasterizer,
// rasterizes each accepted vertex on its own and compares every pixel
// transfer with the oldest cell still due, field by field.
// ----------------------------------------------------------------------------
module pcr_raster_checker
  import pcr_pkg::*;
(
  input  wire                clk_i,
  input  wire                rst_ni,
  pcr_vertex_if              vtx_i,
  pcr_pixel_if               pix_i,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire                pready,
  input  wire [CfgAddrW-1:0] paddr,
  input  wire [31:0]         pwdata,
  output int                 field_errors_o,
  output int                 cells_due_o
);

  typedef struct packed {
    logic [5:0] col;
    logic [5:0] row;
    glyph_e     glyph;
    logic       last;
  } cell_t;

  cell_t      due_cells[$];
  logic [6:0] columns_reg;
  logic [6:0] rows_reg;
  logic [5:0] prev_col;
  logic [5:0] prev_row;
  logic       have_prev;
  int         field_errors = 0;
  int         cells_due = 0;

  assign field_errors_o = field_errors;
  assign cells_due_o    = cells_due;

  function automatic int floor_quot(int n, int d);
    int q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic cell_t cell_at(int cx, int cy, glyph_e g);
    cell_t c;
    c.col   = cx[5:0];
    c.row   = cy[5:0];
    c.glyph = g;
    c.last  = 1'b0;
    return c;
  endfunction

  function automatic void note_mismatch(string field, int want, int got);
    $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    field_errors++;
  endfunction

  function automatic void rasterize_vertex(int x, int y);
    cell_t  cells[$];
    cell_t  c;
    int     col_lim, row_lim, px, py, dx, dy, adx, ady, lo, num, k, major;
    glyph_e slope_glyph;
    col_lim = (columns_reg > GridColumns) ? int'(GridColumns) : int'(columns_reg);
    row_lim = (rows_reg > GridRows) ? int'(GridRows) : int'(rows_reg);
    if (x < 0 || x >= col_lim || y < 0 || y >= row_lim) return;
    cells.push_back(cell_at(x, y, GL_DOT));
    if (have_prev) begin
      px  = int'(prev_col);
      py  = int'(prev_row);
      dx  = x - px;
      dy  = y - py;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      if (dx != 0 && dy == 0) begin
        lo = (x < px) ? x : px;
        for (k = 1; k < adx; k++) cells.push_back(cell_at(lo + k, y, GL_DASH));
      end else if (dx == 0 && dy != 0) begin
        lo = (y < py) ? y : py;
        for (k = 1; k < ady; k++) cells.push_back(cell_at(x, lo + k, GL_BAR));
      end else if (dx != 0 && dy != 0) begin
        slope_glyph = ((dx > 0) == (dy > 0)) ? GL_BACKSLASH : GL_SLASH;
        if (ady > adx) begin
          if (ady > 8 * adx) slope_glyph = GL_BAR;
          lo  = (y < py) ? y : py;
          num = (dy < 0) ? -dx : dx;
          for (k = 1; k < ady; k++) begin
            major = lo + k;
            cells.push_back(cell_at(px + floor_quot((major - py) * num, ady), major,
                                    slope_glyph));
          end
        end else begin
          if (8 * ady < adx) slope_glyph = GL_DASH;
          lo  = (x < px) ? x : px;
          num = (dx < 0) ? -dy : dy;
          for (k = 1; k < adx; k++) begin
            major = lo + k;
            cells.push_back(cell_at(major, py + floor_quot((major - px) * num, adx),
                                    slope_glyph));
          end
        end
      end
    end
    prev_col  = x[5:0];
    prev_row  = y[5:0];
    have_prev = 1'b1;
    foreach (cells[i]) begin
      c      = cells[i];
      c.last = (i == cells.size() - 1);
      due_cells.push_back(c);
    end
  endfunction

  function automatic void check_pixel();
    cell_t want;
    if (due_cells.size() == 0) begin
      $error("pixel transfer with nothing due: x %0d y %0d glyph %0d last %0d",
             pix_i.pixel_x, pix_i.pixel_y, pix_i.glyph, pix_i.last);
      field_errors++;
      return;
    end
    want = due_cells.pop_front();
    if (pix_i.pixel_x !== want.col) note_mismatch("pixel_x", want.col, pix_i.pixel_x);
    if (pix_i.pixel_y !== want.row) note_mismatch("pixel_y", want.row, pix_i.pixel_y);
    if (pix_i.glyph !== want.glyph) note_mismatch("glyph", want.glyph, pix_i.glyph);
    if (pix_i.last !== want.last) note_mismatch("last", want.last, pix_i.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_reg = GridColumns;
      rows_reg    = GridRows;
      prev_col    = '0;
      prev_row    = '0;
      have_prev   = 1'b0;
      due_cells.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == (CfgAddrW'(RegColumns) << 2)) columns_reg = pwdata[6:0];
        if (paddr == (CfgAddrW'(RegRows) << 2)) rows_reg = pwdata[6:0];
      end
      if (pix_i.valid && pix_i.ready) check_pixel();
      if (vtx_i.valid && vtx_i.ready) rasterize_vertex(vtx_i.point_x, vtx_i.point_y);
    end
    cells_due = due_cells.size();
  end

endmodule

@@ test/tb_polyline_char_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// tb_polyline_char_rasterizer_core
// Drives directed and random polylines into the rasterizer under several grid
// sizes, with random gaps and stalls on both channels and one long pixel
// hold-off; the checker beside the block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb_polyline_char_rasterizer_core;

  localparam int CycleLimit   = 1_200_000;
  localparam int SettleCycles = 80;
  localparam int HoldCycles   = 300;
  localparam int DirectedLen  = 23;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [pcr_pkg::CfgAddrW-1:0] paddr;
  logic [31:0]                  pwdata;
  logic [31:0]                  prdata;
  logic                         pready;

  int field_errors;
  int cells_due;

  int          tx_gap_max   = 3;
  int          rx_stall_max = 3;
  bit          rx_hold_req  = 1'b0;
  int          col_limit    = 64;
  int          row_limit    = 64;
  int          last_x       = 0;
  int          last_y       = 0;
  int unsigned cycle_count  = 0;

  int directed_x[DirectedLen] = '{-1, 0, 63, 63, 0, 63, 0, 7, 7, 127, -128, 5, 5, 64, 10,
                                  10, 20, 21, 22, 30, 32, 3, 4};
  int directed_y[DirectedLen] = '{-1, 0, 0, 63, 0, 7, 63, 0, 0, 5, 5, 127, -128, 10, 64,
                                  10, 5, 6, 6, 7, 30, 40, 48};

  pcr_vertex_if vtx ();
  pcr_pixel_if  pix ();

  polyline_char_rasterizer_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vtx_i   (vtx),
    .pix_o   (pix),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pcr_raster_checker raster_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vtx_i          (vtx),
    .pix_i          (pix),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .field_errors_o (field_errors),
    .cells_due_o    (cells_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // pixel receiver
  initial begin
    int stall;
    pix.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        @(negedge clk_i) pix.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end
      stall = $urandom_range(0, rx_stall_max);
      if (stall > 0) begin
        @(negedge clk_i) pix.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i) pix.ready <= 1'b1;
      do @(posedge clk_i); while (!pix.valid);
    end
  end

  task automatic apb_write(input logic index, input logic [6:0] value);
    logic [31:0] data;
    data      = $urandom();
    data[6:0] = value;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= pcr_pkg::CfgAddrW'(index) << 2;
    pwdata  <= data;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_vertex(input int px, input int py);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      @(negedge clk_i) vtx.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    vtx.valid   <= 1'b1;
    vtx.point_x <= px[7:0];
    vtx.point_y <= py[7:0];
    do @(posedge clk_i); while (!vtx.ready);
  endtask

  // drop valid, wait for every due pixel, then let the block go quiet
  task automatic settle();
    @(negedge clk_i) vtx.valid <= 1'b0;
    wait (cells_due == 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic pick_vertex(output int px, output int py);
    int mode, ddx, ddy, major, minor, cx, cy;
    mode = $urandom_range(0, 99);
    if (col_limit == 0 || row_limit == 0 || mode < 10) begin
      px = $urandom_range(0, 255);
      py = $urandom_range(0, 255);
    end else if (mode < 16) begin
      px = $urandom_range(0, col_limit - 1);
      py = $urandom_range(0, row_limit - 1);
      case ($urandom_range(0, 3))
        0: px = col_limit;
        1: py = row_limit;
        2: px = -int'($urandom_range(1, 4));
        default: py = -int'($urandom_range(1, 4));
      endcase
    end else begin
      cx = $urandom_range(0, col_limit - 1);
      cy = $urandom_range(0, row_limit - 1);
      if (mode < 40) begin
        cx = last_x + int'($urandom_range(0, 6)) - 3;
        cy = last_y + int'($urandom_range(0, 6)) - 3;
      end else if (mode < 58) begin
        major = $urandom_range(1, 63);
        minor = major / 8 + int'($urandom_range(0, 1));
        ddx   = $urandom_range(0, 1) ? major : minor;
        ddy   = (ddx == major) ? minor : major;
        if ($urandom_range(0, 1)) ddx = -ddx;
        if ($urandom_range(0, 1)) ddy = -ddy;
        cx = last_x + ddx;
        cy = last_y + ddy;
        if (cx < 0 || cx >= col_limit) cx = last_x - ddx;
        if (cy < 0 || cy >= row_limit) cy = last_y - ddy;
      end else if (mode < 70) begin
        if ($urandom_range(0, 1)) cx = last_x;
        else cy = last_y;
      end
      if (cx < 0 || cx >= col_limit) cx = $urandom_range(0, col_limit - 1);
      if (cy < 0 || cy >= row_limit) cy = $urandom_range(0, row_limit - 1);
      last_x = cx;
      last_y = cy;
      px     = cx;
      py     = cy;
    end
  endtask

  initial begin
    int cols, rows, count, px, py;
    bit hold;
    rst_ni      = 1'b0;
    vtx.valid   = 1'b0;
    vtx.point_x = '0;
    vtx.point_y = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    for (int i = 0; i < DirectedLen; i++) send_vertex(directed_x[i], directed_y[i]);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      hold = 1'b0;
      case (phase)
        0: begin
          cols = 127; rows = 127; count = 60; tx_gap_max = 2; rx_stall_max = 9;
          hold = 1'b1;
        end
        1: begin cols = 1;  rows = 1;   count = 15; tx_gap_max = 5; rx_stall_max = 5; end
        2: begin cols = 0;  rows = 0;   count = 10; tx_gap_max = 9; rx_stall_max = 0; end
        3: begin cols = 2;  rows = 64;  count = 40; tx_gap_max = 0; rx_stall_max = 0; end
        4: begin cols = 64; rows = 2;   count = 40; tx_gap_max = 0; rx_stall_max = 9; end
        5: begin
          cols = $urandom_range(1, 64); rows = $urandom_range(1, 64);
          count = 60; tx_gap_max = 9; rx_stall_max = 3;
        end
        6: begin cols = 64; rows = 64;  count = 100; tx_gap_max = 9; rx_stall_max = 0; end
        default: begin
          cols = $urandom_range(1, 127); rows = $urandom_range(1, 127);
          count = 100; tx_gap_max = 9; rx_stall_max = 9;
        end
      endcase
      apb_write(pcr_pkg::RegColumns, cols[6:0]);
      apb_write(pcr_pkg::RegRows, rows[6:0]);
      col_limit = (cols > 64) ? 64 : cols;
      row_limit = (rows > 64) ? 64 : rows;
      if (hold) rx_hold_req = 1'b1;
      for (int n = 0; n < count; n++) begin
        pick_vertex(px, py);
        send_vertex(px, py);
      end
      settle();
    end

    if (field_errors == 0 && cells_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
